// File: rtl/tcw_pkg.sv
// shared types, constants and sizes of the text console writer
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;

    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

    // derived widths
    localparam int ADDR_W   = $clog2(CELL_COUNT);
    localparam int IDX_W    = $clog2(CELL_COUNT + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int TAB_W    = $clog2(TAB_WIDTH + 1);
    localparam int CHAR_W   = 8;
    localparam int CURSOR_W = 11;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_VALUE   = 8'h0F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op         operation;
        logic [7:0]  character;
        logic [4:0]  row;
        logic [6:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_position;
        logic [7:0]          cell_character;
        logic [7:0]          cell_attribute;
    } t_out_item;

endpackage

// File: rtl/text_console_writer.sv
// text console writer top level: screen store, cursor and operation sequencer
//
// A character terminal that keeps a ROWS x COLUMNS text store (25 x 80 by default)
// in one synchronous ram and a linear cursor (row*COLUMNS+column). Each input
// transaction is one operation and gives exactly one output transaction carrying the
// cursor after the operation and, for a cell read, the stored character with attribute
// 0x0F (both zero otherwise). The single write port and the single read port of the
// screen ram set the pace: a scroll walks the whole store once, after the write of a
// byte or tab space that reaches the end of the store (the rest of a tab goes on in
// the new last row), or at once for a newline on the last row; clear also walks the
// whole store once. After reset the block fills the store with spaces and holds
// o_in_stall high meanwhile. The block works on one operation at a time, but it takes
// the next input transaction while the previous result still waits in the output
// register.
module text_console_writer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tcw_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcw_pkg::t_out_item o_out_data
);

    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,    // reset fill of the store with spaces
        ST_IDLE,    // waiting for an input transaction
        ST_PLAIN,   // write one character at the cursor and advance
        ST_SCROLL,  // copy every row up one and blank the last row
        ST_CLEAR,   // blank the whole store
        ST_READ,    // read data of a cell read comes back
        ST_DONE     // result ready, waiting to go to the output register
    } t_state;

    // sequencer state
    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;        // sweep counter for fill, clear, scroll
    logic [ADDR_W-1:0]   r_cursor, n_cursor;  // linear cursor, always below CELL_COUNT
    logic [COL_W-1:0]    r_col, n_col;        // column part of the cursor
    logic [TAB_W-1:0]    r_left, n_left;      // plain writes still to do
    logic [CHAR_W-1:0]   r_char, n_char;      // character for plain writes
    logic [CHAR_W-1:0]   r_res_char, n_res_char;
    logic [CHAR_W-1:0]   r_res_attr, n_res_attr;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    // ram ports
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CHAR_W-1:0]   wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]   rd_data;

    // result hand-off
    logic                fin;
    logic [CHAR_W-1:0]   fin_char;
    logic [CHAR_W-1:0]   fin_attr;
    logic                out_free;

    // clamped target of move_cursor and a cell read
    logic [ROW_W-1:0]    row_c;
    logic [COL_W-1:0]    col_c;
    logic [ADDR_W-1:0]   target_addr;

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // input is taken only between operations
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // output register is free now or emptied at this edge
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (32'(i_in_data.row) > ROWS - 1) begin
            row_c = ROW_W'(ROWS - 1);
        end else begin
            row_c = ROW_W'(i_in_data.row);
        end
        if (32'(i_in_data.column) > COLUMNS - 1) begin
            col_c = COL_W'(COLUMNS - 1);
        end else begin
            col_c = COL_W'(i_in_data.column);
        end
        target_addr = ADDR_W'(IDX_W'(row_c) * IDX_W'(COLUMNS) + IDX_W'(col_c));
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cursor    = r_cursor;
        n_col       = r_col;
        n_left      = r_left;
        n_char      = r_char;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = r_cursor;
        wr_data     = CH_SPACE;
        rd_en       = 1'b0;
        rd_addr     = target_addr;
        fin         = 1'b0;
        fin_char    = '0;
        fin_attr    = '0;

        unique case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[ADDR_W-1:0];
                if (r_idx == IDX_W'(CELL_COUNT - 1)) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res_char = '0;
                    n_res_attr = '0;
                    unique case (i_in_data.operation)
                        OP_PUT: begin
                            priority if (i_in_data.character == CH_NEWLINE) begin
                                n_col = '0;
                                if (r_cursor >= ADDR_W'(LAST_ROW_START)) begin
                                    // newline off the last row scrolls
                                    n_cursor = ADDR_W'(LAST_ROW_START);
                                    n_idx    = '0;
                                    n_left   = '0;
                                    n_state  = ST_SCROLL;
                                end else begin
                                    n_cursor = r_cursor + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
                                    n_state  = ST_DONE;
                                end
                            end else if (i_in_data.character == CH_BACKSPACE) begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - ADDR_W'(1);
                                    n_col    = (r_col == '0) ? COL_W'(COLUMNS - 1)
                                                             : r_col - COL_W'(1);
                                end
                                // blank the cell under the new cursor
                                wr_en   = 1'b1;
                                wr_addr = n_cursor;
                                n_state = ST_DONE;
                            end else if (i_in_data.character == CH_TAB) begin
                                n_char  = CH_SPACE;
                                n_left  = TAB_W'(TAB_WIDTH);
                                n_state = ST_PLAIN;
                            end else begin
                                n_char  = i_in_data.character;
                                n_left  = TAB_W'(1);
                                n_state = ST_PLAIN;
                            end
                        end
                        OP_MOVE: begin
                            n_cursor = target_addr;
                            n_col    = col_c;
                            n_state  = ST_DONE;
                        end
                        OP_CLEAR: begin
                            n_cursor = '0;
                            n_col    = '0;
                            n_idx    = '0;
                            n_state  = ST_CLEAR;
                        end
                        OP_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = target_addr;
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_PLAIN: begin
                wr_en   = 1'b1;
                wr_addr = r_cursor;
                wr_data = r_char;
                n_left  = r_left - TAB_W'(1);
                if (r_cursor == ADDR_W'(CELL_COUNT - 1)) begin
                    // cursor reaches the end of the store
                    n_cursor = ADDR_W'(LAST_ROW_START);
                    n_col    = '0;
                    n_idx    = '0;
                    n_state  = ST_SCROLL;
                end else begin
                    n_cursor = r_cursor + ADDR_W'(1);
                    n_col    = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + COL_W'(1);
                    if (r_left == TAB_W'(1)) begin
                        fin = 1'b1;
                    end
                end
            end

            ST_SCROLL: begin
                // read cell idx+COLUMNS now, write it to idx in the next cycle
                rd_addr = ADDR_W'(r_idx + IDX_W'(COLUMNS));
                if (r_idx < IDX_W'(CELL_COUNT - COLUMNS)) begin
                    rd_en = 1'b1;
                end
                if (r_idx != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(r_idx - IDX_W'(1));
                    wr_data = (r_idx <= IDX_W'(CELL_COUNT - COLUMNS)) ? rd_data : CH_SPACE;
                end
                if (r_idx == IDX_W'(CELL_COUNT)) begin
                    n_idx = '0;
                    if (r_left != '0) begin
                        // rest of a tab continues on the new last row
                        n_state = ST_PLAIN;
                    end else begin
                        fin = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[ADDR_W-1:0];
                if (r_idx == IDX_W'(CELL_COUNT - 1)) begin
                    n_idx = '0;
                    fin   = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_READ: begin
                fin      = 1'b1;
                fin_char = rd_data;
                fin_attr = ATTR_VALUE;
            end

            ST_DONE: begin
                fin      = 1'b1;
                fin_char = r_res_char;
                fin_attr = r_res_attr;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it until there is room
        if (fin) begin
            if (out_free) begin
                n_out_valid           = 1'b1;
                n_out.cursor_position = CURSOR_W'(n_cursor);
                n_out.cell_character  = fin_char;
                n_out.cell_attribute  = fin_attr;
                n_state               = ST_IDLE;
            end else begin
                n_res_char = fin_char;
                n_res_attr = fin_attr;
                n_state    = ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_col       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cursor    <= n_cursor;
            r_col       <= n_col;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // cursor never leaves the store
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cursor < ADDR_W'(CELL_COUNT)) && (r_col < COL_W'(COLUMNS)))
        else $error("cursor outside the store");

    // while a result waits in ST_DONE, the output register is valid at the next edge
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid)
        else $error("result not handed to the output register");

    // the scroll copy never reads and writes the same cell in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("ram read and write collide");

    // read data reaches the result in the cycle after the read is issued
    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_in_data.operation == OP_READ)
        |=> (r_state == ST_READ))
        else $error("cell read lost its data cycle");

endmodule

// File: rtl/tcw_ram.sv
// generic single write port, single read port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
